/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define CHK_IMPLY(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence in the cycle after.
`define CHK_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/olle_pkg.sv */
// ----------------------------------------------------------------------------
// olle_pkg
// Types and constants for the ordered linked list engine.
// ----------------------------------------------------------------------------
package olle_pkg;

    localparam logic [3:0] FN_INS_SORT = 4'd0;
    localparam logic [3:0] FN_DEL_KEY  = 4'd1;
    localparam logic [3:0] FN_INS_LAST = 4'd2;
    localparam logic [3:0] FN_DEL_LAST = 4'd3;
    localparam logic [3:0] FN_INS_FRST = 4'd4;
    localparam logic [3:0] FN_DEL_FRST = 4'd5;
    localparam logic [3:0] FN_INVERT   = 4'd6;
    localparam logic [3:0] FN_CLEAR    = 4'd7;
    localparam logic [3:0] FN_PRINT    = 4'd8;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam int MAX_OUT = 32;

    typedef struct packed {
        logic [3:0]  func;
        logic signed [31:0] key;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic signed [31:0] item_key;
        logic [5:0]  position;
        logic        last;
    } t_rsp;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_READ,
        OP_STEP,
        OP_LINK_SORT,
        OP_LINK_BACK,
        OP_LINK_FRONT,
        OP_UNLINK_CUR,
        OP_UNLINK_BACK,
        OP_UNLINK_FRONT,
        OP_SWAP_CUR,
        OP_SWAP_ENDS,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic        empty;
        logic        full;
        logic        walk_done;
        logic        key_ge;
        logic        key_eq;
        logic        print_done;
        logic [5:0]  index;
        logic signed [31:0] cur_key;
    } t_sts;

endpackage

/* rtl/olle_stream_if.sv */
// ----------------------------------------------------------------------------
// olle_stream_if
// Valid/ready channel carrying one request or one result.
// ----------------------------------------------------------------------------
interface olle_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/ordered_linked_list_engine_core.sv */
// ----------------------------------------------------------------------------
// ordered_linked_list_engine_core
// Bounded doubly linked list of signed keys with sorted insert and print.
// ----------------------------------------------------------------------------
// One request is handled at a time: the next is accepted only after the
// result of the last one has been taken. Sorted insert, key delete, invert
// and print walk the list node by node, each node by a registered node
// memory read and then a compare. Print emits one result per node, at most
// 32, and stalls the walk while a result waits.
module ordered_linked_list_engine_core
    import olle_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    olle_stream_if.sink   i_req,
    olle_stream_if.source o_rsp
);
    t_cmd w_cmd;
    t_sts w_sts;

    olle_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (i_req),
        .o_rsp  (o_rsp),
        .o_cmd  (w_cmd),
        .i_sts  (w_sts)
    );

    olle_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (w_cmd),
        .i_key  (i_req.data.key),
        .o_sts  (w_sts)
    );
endmodule

/* rtl/olle_datapath.sv */
// ----------------------------------------------------------------------------
// olle_datapath
// Node pool memories, list pointers and the walk cursor.
// ----------------------------------------------------------------------------
module olle_datapath
    import olle_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic signed [31:0] i_key,
    output t_sts        o_sts
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [31:0] r_keys [CAPACITY];
    logic [AW-1:0]      r_next [CAPACITY];
    logic [AW-1:0]      r_prev [CAPACITY];
    logic [CAPACITY-1:0] r_used;
    logic [AW-1:0]      r_front, r_back, r_cur, r_free;
    logic [CW-1:0]      r_count, r_idx;
    logic signed [31:0] r_key, r_cur_key;
    logic [AW-1:0]      r_cur_next, r_cur_prev;
    logic               r_full;

    logic [AW-1:0] n_free;
    logic          n_full;

    always_comb begin
        n_free = '0;
        n_full = 1'b1;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                n_free = AW'(i);
                n_full = 1'b0;
            end
        end
    end

    // Memory reads of the cursor node, registered.
    always_ff @(posedge i_clk) begin
        r_cur_key  <= r_keys[r_cur];
        r_cur_next <= r_next[r_cur];
        r_cur_prev <= r_prev[r_cur];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_count <= '0;
            r_front <= '0;
            r_back  <= '0;
            r_cur   <= '0;
            r_idx   <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_key  <= i_key;
                    r_cur  <= r_front;
                    r_idx  <= '0;
                    r_free <= n_free;
                    r_full <= n_full;
                end
                OP_STEP: begin
                    r_cur <= r_cur_next;
                    r_idx <= r_idx + 1'b1;
                end
                OP_LINK_SORT, OP_LINK_BACK, OP_LINK_FRONT: begin
                    r_keys[r_free] <= r_key;
                    r_used[r_free] <= 1'b1;
                    r_count <= r_count + 1'b1;
                    if (r_count == '0) begin
                        r_front <= r_free;
                        r_back  <= r_free;
                    end else if (i_cmd.op == OP_LINK_BACK) begin
                        r_prev[r_free] <= r_back;
                        r_next[r_back] <= r_free;
                        r_back <= r_free;
                    end else if (i_cmd.op == OP_LINK_FRONT) begin
                        r_next[r_free]  <= r_front;
                        r_prev[r_front] <= r_free;
                        r_front <= r_free;
                    end else begin
                        if (r_cur == r_front) begin
                            r_front <= r_free;
                        end else begin
                            r_next[r_cur_prev] <= r_free;
                            r_prev[r_free]     <= r_cur_prev;
                        end
                        r_next[r_free] <= r_cur;
                        r_prev[r_cur]  <= r_free;
                    end
                end
                OP_UNLINK_CUR: begin
                    if (r_cur == r_front) r_front <= r_cur_next;
                    else r_next[r_cur_prev] <= r_cur_next;
                    if (r_cur == r_back) r_back <= r_cur_prev;
                    else r_prev[r_cur_next] <= r_cur_prev;
                    r_used[r_cur] <= 1'b0;
                    r_count <= r_count - 1'b1;
                end
                OP_SWAP_CUR: begin
                    r_next[r_cur] <= r_cur_prev;
                    r_prev[r_cur] <= r_cur_next;
                    r_cur <= r_cur_next;
                    r_idx <= r_idx + 1'b1;
                end
                OP_SWAP_ENDS: begin
                    r_front <= r_back;
                    r_back  <= r_front;
                end
                OP_UNLINK_BACK: r_cur <= r_back;
                OP_UNLINK_FRONT: r_cur <= r_front;
                OP_CLEAR: begin
                    r_used  <= '0;
                    r_count <= '0;
                    r_front <= '0;
                    r_back  <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_sts.empty      = (r_count == '0);
    assign o_sts.full       = r_full;
    assign o_sts.walk_done  = (r_idx >= r_count);
    assign o_sts.key_ge     = (r_cur_key >= r_key);
    assign o_sts.key_eq     = (r_cur_key == r_key);
    assign o_sts.print_done = (r_idx + 1'b1 >= r_count) || (32'(r_idx) + 1 >= MAX_OUT);
    assign o_sts.index      = 6'(r_idx);
    assign o_sts.cur_key    = r_cur_key;
endmodule

/* rtl/olle_ctrl.sv */
// ----------------------------------------------------------------------------
// olle_ctrl
// Sequencer for list operations and result output.
// ----------------------------------------------------------------------------
module olle_ctrl
    import olle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    olle_stream_if.sink   i_req,
    olle_stream_if.source o_rsp,
    output t_cmd        o_cmd,
    input  t_sts        i_sts
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;
    localparam logic [2:0] S_UNLK = 3'd5;

    logic [2:0] r_state, n_state;
    logic [3:0] r_func;
    logic       r_vld, n_vld;
    t_rsp       r_rsp, n_rsp;

    assign i_req.ready = (r_state == S_IDLE) && !r_vld;
    assign o_rsp.valid = r_vld;
    assign o_rsp.data  = r_rsp;

    always_comb begin
        n_state   = r_state;
        n_vld     = r_vld && !o_rsp.ready;
        n_rsp     = r_rsp;
        o_cmd.op  = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                n_rsp   = '{status: ST_OK, item_key: '0, position: '0, last: 1'b1};
                n_state = S_OUT;
                priority case (r_func)
                    FN_INS_SORT, FN_INS_LAST, FN_INS_FRST: begin
                        if (i_sts.full) n_rsp.status = ST_FULL;
                        else if (r_func == FN_INS_LAST || i_sts.empty) o_cmd.op = OP_LINK_BACK;
                        else if (r_func == FN_INS_FRST) o_cmd.op = OP_LINK_FRONT;
                        else n_state = S_RD;
                    end
                    FN_DEL_KEY, FN_INVERT, FN_PRINT: begin
                        if (i_sts.empty) n_rsp.status = ST_EMPTY;
                        else n_state = S_RD;
                    end
                    FN_DEL_LAST, FN_DEL_FRST: begin
                        if (i_sts.empty) n_rsp.status = ST_EMPTY;
                        else begin
                            o_cmd.op = (r_func == FN_DEL_LAST) ? OP_UNLINK_BACK
                                                               : OP_UNLINK_FRONT;
                            n_state = S_UNLK;
                        end
                    end
                    FN_CLEAR: o_cmd.op = OP_CLEAR;
                    default: begin
                    end
                endcase
                if (n_state == S_OUT) n_vld = 1'b1;
            end
            S_UNLK: n_state = S_RD;
            S_RD: n_state = S_CHK;
            S_CHK: begin
                n_rsp = '{status: ST_OK, item_key: '0, position: '0, last: 1'b1};
                priority case (r_func)
                    FN_INS_SORT: begin
                        if (i_sts.walk_done) begin
                            o_cmd.op = OP_LINK_BACK;
                            n_state = S_OUT; n_vld = 1'b1;
                        end else if (i_sts.key_ge) begin
                            o_cmd.op = OP_LINK_SORT;
                            n_state = S_OUT; n_vld = 1'b1;
                        end else begin
                            o_cmd.op = OP_STEP; n_state = S_RD;
                        end
                    end
                    FN_DEL_KEY: begin
                        if (i_sts.walk_done) begin
                            n_rsp.status = ST_NOTFOUND;
                            n_state = S_OUT; n_vld = 1'b1;
                        end else if (i_sts.key_eq) begin
                            o_cmd.op = OP_UNLINK_CUR;
                            n_state = S_OUT; n_vld = 1'b1;
                        end else begin
                            o_cmd.op = OP_STEP; n_state = S_RD;
                        end
                    end
                    FN_INVERT: begin
                        if (i_sts.walk_done) begin
                            o_cmd.op = OP_SWAP_ENDS;
                            n_state = S_OUT; n_vld = 1'b1;
                        end else begin
                            o_cmd.op = OP_SWAP_CUR; n_state = S_RD;
                        end
                    end
                    FN_DEL_LAST, FN_DEL_FRST: begin
                        o_cmd.op = OP_UNLINK_CUR;
                        n_state = S_OUT; n_vld = 1'b1;
                    end
                    default: begin
                        if (!r_vld || o_rsp.ready) begin
                            n_rsp.item_key = i_sts.cur_key;
                            n_rsp.position = i_sts.index;
                            n_rsp.last     = i_sts.print_done;
                            n_vld = 1'b1;
                            if (i_sts.print_done) n_state = S_OUT;
                            else begin
                                o_cmd.op = OP_STEP; n_state = S_RD;
                            end
                        end else n_rsp = r_rsp;
                    end
                endcase
            end
            S_OUT: if (!r_vld || o_rsp.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vld   <= n_vld;
        end
        r_rsp <= n_rsp;
        if (i_req.valid && i_req.ready) r_func <= i_req.data.func;
    end
endmodule

/* rtl/olle_checker.sv */
// ----------------------------------------------------------------------------
// olle_checker
// Port-level checks of the list engine handshakes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module olle_checker
    import olle_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_vld,
    input logic i_rdy,
    input logic o_vld,
    input logic o_rdy,
    input t_rsp o_dat
);
    `CHK_NEXT(a_hold, i_clk, i_rst_n, o_vld && !o_rdy, o_vld && $stable(o_dat), "result dropped")
    `CHK_IMPLY(a_nopos, i_clk, i_rst_n, o_vld && o_dat.status != ST_OK, o_dat.last, "status not last")
    `CHK_IMPLY(a_busy, i_clk, i_rst_n, o_vld, !i_rdy, "request taken while result waits")
    `CHK_NEXT(a_one, i_clk, i_rst_n, i_vld && i_rdy, !i_rdy, "two requests in flight")
endmodule

bind ordered_linked_list_engine_core olle_checker u_chk (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_vld  (i_req.valid),
    .i_rdy  (i_req.ready),
    .o_vld  (o_rsp.valid),
    .o_rdy  (o_rsp.ready),
    .o_dat  (o_rsp.data)
);

/* verif/olle_checker.sv */
// ----------------------------------------------------------------------------
// olle_scoreboard
// Watches the request and result channels of the linked list engine, keeps
// its own model of the list and compares every result with the prediction.
// ----------------------------------------------------------------------------
module olle_scoreboard
    import olle_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  t_req        i_req_data,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  t_rsp        i_rsp_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count,
    output int          o_request_count,
    output int          o_max_items
);

    // The list is kept as an ordered queue of keys, which is all that the
    // results can observe.
    logic signed [31:0] list_keys[$];
    t_rsp               expected_rsps[$];

    function automatic t_rsp make_rsp(logic [1:0] st, logic signed [31:0] k,
                                      logic [5:0] pos, logic lst);
        t_rsp r;
        r.status   = st;
        r.item_key = k;
        r.position = pos;
        r.last     = lst;
        return r;
    endfunction

    task automatic apply_request(t_req rq);
        int          idx;
        int          cnt;
        logic [1:0]  st;
        logic signed [31:0] tmp[$];
        idx = -1;
        st  = ST_OK;
        if (rq.func == FN_PRINT) begin
            if (list_keys.size() == 0) begin
                expected_rsps.push_back(make_rsp(ST_EMPTY, '0, '0, 1'b1));
            end else begin
                cnt = (list_keys.size() < MAX_OUT) ? list_keys.size() : MAX_OUT;
                for (int i = 0; i < cnt; i++) begin
                    expected_rsps.push_back(make_rsp(ST_OK, list_keys[i], 6'(i),
                                                     i == cnt - 1));
                end
            end
            return;
        end
        case (rq.func)
            FN_INS_SORT, FN_INS_LAST, FN_INS_FRST: begin
                if (list_keys.size() >= CAPACITY) begin
                    st = ST_FULL;
                end else if (rq.func == FN_INS_LAST) begin
                    list_keys.push_back(rq.key);
                end else if (rq.func == FN_INS_FRST) begin
                    list_keys.push_front(rq.key);
                end else begin
                    foreach (list_keys[i]) begin
                        if (idx < 0 && list_keys[i] >= rq.key) idx = i;
                    end
                    if (idx < 0) list_keys.push_back(rq.key);
                    else list_keys.insert(idx, rq.key);
                end
            end
            FN_DEL_KEY: begin
                if (list_keys.size() == 0) begin
                    st = ST_EMPTY;
                end else begin
                    foreach (list_keys[i]) begin
                        if (idx < 0 && list_keys[i] == rq.key) idx = i;
                    end
                    if (idx < 0) st = ST_NOTFOUND;
                    else list_keys.delete(idx);
                end
            end
            FN_DEL_LAST: begin
                if (list_keys.size() == 0) st = ST_EMPTY;
                else void'(list_keys.pop_back());
            end
            FN_DEL_FRST: begin
                if (list_keys.size() == 0) st = ST_EMPTY;
                else void'(list_keys.pop_front());
            end
            FN_INVERT: begin
                if (list_keys.size() == 0) begin
                    st = ST_EMPTY;
                end else begin
                    foreach (list_keys[i]) tmp.push_front(list_keys[i]);
                    list_keys = tmp;
                end
            end
            FN_CLEAR: list_keys.delete();
            default: ;
        endcase
        expected_rsps.push_back(make_rsp(st, '0, '0, 1'b1));
    endtask

    task automatic compare_rsp(t_rsp got);
        t_rsp want;
        if (expected_rsps.size() == 0) begin
            $error("unexpected result: status %0d key %0d", got.status, got.item_key);
            o_fail_count++;
            return;
        end
        want = expected_rsps.pop_front();
        if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            o_fail_count++;
        end
        if (got.item_key !== want.item_key) begin
            $error("item_key: expected %0d, actual %0d", want.item_key, got.item_key);
            o_fail_count++;
        end
        if (got.position !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, got.position);
            o_fail_count++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count    = 0;
        o_result_count  = 0;
        o_request_count = 0;
        o_max_items     = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_rsp_valid && i_rsp_ready) begin
                compare_rsp(i_rsp_data);
                o_result_count++;
            end
            if (i_req_valid && i_req_ready) begin
                apply_request(i_req_data);
                o_request_count++;
                if (list_keys.size() > o_max_items) o_max_items = list_keys.size();
            end
        end
    end

    assign o_pending = expected_rsps.size();

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives random and directed list requests into the linked list engine
// under several idle and stall patterns; a checker module judges results.
// ----------------------------------------------------------------------------
module tb_top;
    import olle_pkg::*;

    localparam int CAPACITY  = 32;
    localparam int N_RANDOM  = 304;
    localparam int MAX_CYCLE = 2000000;

    logic i_clk;
    logic i_rst_n;
    int   cycle_count;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   fail_count;
    int   pending;
    int   result_count;
    int   request_count;
    int   max_items;
    int   list_len;

    olle_stream_if #(.T(t_req)) req_if ();
    olle_stream_if #(.T(t_rsp)) rsp_if ();

    ordered_linked_list_engine_core #(.CAPACITY(CAPACITY)) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    olle_scoreboard #(.CAPACITY(CAPACITY)) i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (req_if.valid),
        .i_req_ready     (req_if.ready),
        .i_req_data      (req_if.data),
        .i_rsp_valid     (rsp_if.valid),
        .i_rsp_ready     (rsp_if.ready),
        .i_rsp_data      (rsp_if.data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_result_count  (result_count),
        .o_request_count (request_count),
        .o_max_items     (max_items)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.data    = '0;
        rsp_if.ready   = 1'b0;
        recv_stall_pct = 0;
        cycle_count    = 0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // The request stays valid after acceptance until the next idle cycle or
    // drain lowers it, so that valid gets one update per clock edge.
    task automatic send_request(logic [3:0] fn, logic signed [31:0] k);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= '{func: fn, key: k};
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        // Track the list length for choosing keys and operations.
        case (fn)
            FN_INS_SORT, FN_INS_LAST, FN_INS_FRST:
                if (list_len < CAPACITY) list_len++;
            FN_DEL_LAST, FN_DEL_FRST: if (list_len > 0) list_len--;
            FN_CLEAR: list_len = 0;
            default: ;
        endcase
    endtask

    function automatic logic signed [31:0] random_key();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'($urandom_range(15)) - 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic drain();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic random_phase(int count);
        logic [3:0] fn;
        int         pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 45)      fn = (list_len >= CAPACITY) ? FN_DEL_FRST : FN_INS_SORT;
            else if (pick < 55) fn = FN_INS_LAST;
            else if (pick < 62) fn = FN_INS_FRST;
            else if (pick < 74) fn = FN_DEL_KEY;
            else if (pick < 78) fn = FN_DEL_LAST;
            else if (pick < 82) fn = FN_DEL_FRST;
            else if (pick < 86) fn = FN_INVERT;
            else if (pick < 87) fn = FN_CLEAR;
            else if (pick < 97) fn = FN_PRINT;
            else                fn = 4'($urandom_range(15, 9));
            if (fn == FN_DEL_KEY) list_len = (list_len > 0) ? list_len - 1 : 0;
            send_request(fn, random_key());
            // A key delete may miss; resync the estimate from the checker.
            if (fn == FN_DEL_KEY) begin
                drain();
                list_len = i_checker.list_keys.size();
            end
        end
    endtask

    initial begin
        send_idle_pct = 0;
        list_len      = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(FN_PRINT, 0);
        send_request(FN_DEL_KEY, 5);
        send_request(FN_DEL_LAST, 0);
        send_request(FN_DEL_FRST, 0);
        send_request(FN_INVERT, 0);
        send_request(FN_INS_SORT, 32'sh7fffffff);
        send_request(FN_INS_SORT, 32'sh80000000);
        send_request(FN_INS_SORT, 0);
        send_request(FN_INS_SORT, 0);
        send_request(FN_INS_LAST, -1);
        send_request(FN_INS_FRST, 32'sh7fffffff);
        send_request(FN_DEL_KEY, 12345);
        send_request(FN_DEL_KEY, 0);
        send_request(FN_INVERT, 0);
        send_request(FN_PRINT, 0);
        send_request(4'd15, -1);
        send_request(FN_CLEAR, 0);
        send_request(FN_CLEAR, 0);
        for (int i = 0; i < CAPACITY + 1; i++) send_request(FN_INS_SORT, random_key());
        send_request(FN_INS_LAST, 1);
        send_request(FN_INS_FRST, 1);
        send_request(FN_PRINT, 0);
        drain();
        send_request(FN_CLEAR, 0);

        random_phase(N_RANDOM / 4);
        send_idle_pct = 83;
        random_phase(N_RANDOM / 4);
        send_idle_pct  = 0;
        recv_stall_pct = 83;
        random_phase(N_RANDOM / 4);
        send_idle_pct  = 27;
        recv_stall_pct = 27;
        random_phase(N_RANDOM / 4);
        recv_stall_pct = 0;
        drain();

        $display("tb: %0d requests and %0d results checked, list grew to %0d keys",
                 request_count, result_count, max_items);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
